FILE: rtl/fpmm_pkg.sv
// ---------------------------------------------------------------------------
// fpmm_pkg: shared types and constants of the fixed-point matrix multiplier
// Field widths, register indexes, controller states and the command types
// that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package fpmm_pkg;

	localparam int ELEM_W     = 32;	// element and result field width
	localparam int DIM_REG_W  = 4;	// dimension register width
	localparam int FRAC_W     = 5;	// fraction_bits register width
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;	// widest register

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_ROWS       = 3'd0,
		REG_INNER_SIZE      = 3'd1,
		REG_RIGHT_COLS      = 3'd2,
		REG_ACCUMULATE_MODE = 3'd3,
		REG_FRACTION_BITS   = 3'd4
	} cfg_reg_t;

	localparam logic [DIM_REG_W-1:0] LEFT_ROWS_RST  = 4'd8;
	localparam logic [DIM_REG_W-1:0] INNER_SIZE_RST = 4'd8;
	localparam logic [DIM_REG_W-1:0] RIGHT_COLS_RST = 4'd8;
	localparam logic                 ACC_MODE_RST   = 1'b0;
	localparam logic [FRAC_W-1:0]    FRAC_BITS_RST  = 5'd16;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_COMPUTE,
		ST_DRAIN
	} fpmm_state_t;

	// Which store takes the element being loaded.
	typedef enum logic [1:0] {
		WR_NONE,
		WR_LEFT,
		WR_RIGHT,
		WR_ADDEND
	} wr_sel_t;

	// Tags of one multiply-accumulate term as it travels down the pipeline.
	typedef struct packed {
		logic valid;
		logic first;		// first term of a result element
		logic last_term;	// last term: the sum is complete
		logic last_result;	// last term of the last result element
	} issue_t;

endpackage

`default_nettype wire

FILE: rtl/fpmm_ram.sv
// ---------------------------------------------------------------------------
// fpmm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module fpmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/fpmm_ctrl.sv
// ---------------------------------------------------------------------------
// fpmm_ctrl: load and compute sequencer of the matrix multiplier
// Counts elements into the three stores, then walks the result elements and
// their inner terms, issuing one multiply-accumulate per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module fpmm_ctrl #(
	parameter int MAX_DIM = 8,
	localparam int DEPTH  = MAX_DIM * MAX_DIM,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             cfg_restart,
	input  logic [fpmm_pkg::DIM_REG_W-1:0]   left_rows,
	input  logic [fpmm_pkg::DIM_REG_W-1:0]   inner_size,
	input  logic [fpmm_pkg::DIM_REG_W-1:0]   right_cols,
	input  logic                             accumulate_mode,
	input  logic                             pipe_busy,
	output logic                             busy,
	output fpmm_pkg::wr_sel_t                wr_sel,
	output logic [ADDR_W-1:0]                wr_addr,
	output logic [ADDR_W-1:0]                rd_left_addr,
	output logic [ADDR_W-1:0]                rd_right_addr,
	output logic [ADDR_W-1:0]                rd_addend_addr,
	output fpmm_pkg::issue_t                 issue
);

	import fpmm_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = $clog2(3 * DEPTH + 1);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_REG_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(d);
		end
		return r;
	endfunction

	fpmm_state_t state_q, state_d;

	logic [DIM_W-1:0]  dim_r, dim_k, dim_c;
	logic [CNT_W-1:0]  n_left, n_lr, n_add, total;
	logic [CNT_W-1:0]  load_cnt_q, pos_off;
	logic              load_acc, load_last;

	logic [DIM_W-1:0]  row_q, col_q, inner_q;
	logic [ADDR_W-1:0] left_base_q, right_ptr_q, elem_q;
	logic              row_end, col_end;

	assign dim_r = clamp_dim(left_rows);
	assign dim_k = clamp_dim(inner_size);
	assign dim_c = clamp_dim(right_cols);

	assign n_left = CNT_W'(dim_r) * CNT_W'(dim_k);
	assign n_lr   = n_left + CNT_W'(dim_k) * CNT_W'(dim_c);
	assign n_add  = accumulate_mode ? CNT_W'(dim_r) * CNT_W'(dim_c) : '0;
	assign total  = n_lr + n_add;

	assign load_acc  = start && (state_q == ST_LOAD);
	assign load_last = (load_cnt_q + CNT_W'(1)) == total;

	// Store selection for the element at the current load position.
	always_comb begin
		if (!load_acc) begin
			wr_sel  = WR_NONE;
			pos_off = load_cnt_q;
		end else if (load_cnt_q < n_left) begin
			wr_sel  = WR_LEFT;
			pos_off = load_cnt_q;
		end else if (load_cnt_q < n_lr) begin
			wr_sel  = WR_RIGHT;
			pos_off = load_cnt_q - n_left;
		end else begin
			wr_sel  = WR_ADDEND;
			pos_off = load_cnt_q - n_lr;
		end
	end
	assign wr_addr = pos_off[ADDR_W-1:0];

	assign row_end = (row_q == dim_r - DIM_W'(1));
	assign col_end = (col_q == dim_c - DIM_W'(1));

	assign issue.valid       = (state_q == ST_COMPUTE);
	assign issue.first       = (inner_q == '0);
	assign issue.last_term   = (inner_q == dim_k - DIM_W'(1));
	assign issue.last_result = issue.last_term && row_end && col_end;

	assign rd_left_addr   = left_base_q + ADDR_W'(inner_q);
	assign rd_right_addr  = right_ptr_q;
	assign rd_addend_addr = elem_q;

	assign busy = (state_q != ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (load_acc && load_last) begin
					state_d = ST_COMPUTE;
				end
			end
			ST_COMPUTE: begin
				if (issue.last_result) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (cfg_restart || (load_acc && load_last)) begin
			load_cnt_q <= '0;
		end else if (load_acc) begin
			load_cnt_q <= load_cnt_q + CNT_W'(1);
		end
	end

	// Walk of the result elements and their inner terms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			inner_q     <= '0;
			left_base_q <= '0;
			right_ptr_q <= '0;
			elem_q      <= '0;
		end else if (state_q == ST_LOAD) begin
			row_q       <= '0;
			col_q       <= '0;
			inner_q     <= '0;
			left_base_q <= '0;
			right_ptr_q <= '0;
			elem_q      <= '0;
		end else if (state_q == ST_COMPUTE) begin
			if (issue.last_term) begin
				inner_q <= '0;
				elem_q  <= elem_q + ADDR_W'(1);
				if (col_end) begin
					col_q       <= '0;
					row_q       <= row_q + DIM_W'(1);
					left_base_q <= left_base_q + ADDR_W'(dim_k);
					right_ptr_q <= '0;
				end else begin
					col_q       <= col_q + DIM_W'(1);
					right_ptr_q <= ADDR_W'(col_q + DIM_W'(1));
				end
			end else begin
				inner_q     <= inner_q + DIM_W'(1);
				right_ptr_q <= right_ptr_q + ADDR_W'(dim_c);
			end
		end
	end

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> load_cnt_q < total)
		else $error("load count has run past the matrix sizes");

	a_drain_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DRAIN) |-> $past(issue.last_result))
		else $error("drain entered before the final term was issued");

	a_left_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> CNT_W'(rd_left_addr) < n_left)
		else $error("left store read outside the loaded matrix");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> wr_sel == WR_NONE)
		else $error("store written while computing");

endmodule

`default_nettype wire

FILE: rtl/fpmm_datapath.sv
// ---------------------------------------------------------------------------
// fpmm_datapath: element stores and multiply-accumulate pipeline
// Holds the three matrix stores and a four-stage pipeline: read, multiply,
// magnitude, scale, then accumulation into the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fpmm_datapath #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32,
	localparam int DEPTH  = MAX_DIM * MAX_DIM,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fpmm_pkg::ELEM_W-1:0]   element_value,
	input  fpmm_pkg::wr_sel_t             wr_sel,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [ADDR_W-1:0]             rd_left_addr,
	input  logic [ADDR_W-1:0]             rd_right_addr,
	input  logic [ADDR_W-1:0]             rd_addend_addr,
	input  fpmm_pkg::issue_t              issue,
	input  logic                          accumulate_mode,
	input  logic [fpmm_pkg::FRAC_W-1:0]   fraction_bits,
	output logic [fpmm_pkg::ELEM_W-1:0]   product_value,
	output logic                          last_element,
	output logic                          result_strobe,
	output logic                          pipe_busy
);

	import fpmm_pkg::*;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int MAG_W  = (PROD_W > ELEM_W) ? PROD_W : ELEM_W;

	logic [DATA_WIDTH-1:0] wdata, left_rd, right_rd, addend_rd;

	assign wdata = element_value[DATA_WIDTH-1:0];

	fpmm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_left_ram (
		.clk   (clk),
		.we    (wr_sel == WR_LEFT),
		.waddr (wr_addr),
		.wdata (wdata),
		.raddr (rd_left_addr),
		.rdata (left_rd)
	);

	fpmm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_right_ram (
		.clk   (clk),
		.we    (wr_sel == WR_RIGHT),
		.waddr (wr_addr),
		.wdata (wdata),
		.raddr (rd_right_addr),
		.rdata (right_rd)
	);

	fpmm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_addend_ram (
		.clk   (clk),
		.we    (wr_sel == WR_ADDEND),
		.waddr (wr_addr),
		.wdata (wdata),
		.raddr (rd_addend_addr),
		.rdata (addend_rd)
	);

	issue_t flags_s1, flags_s2, flags_s3, flags_s4;

	logic signed [DATA_WIDTH-1:0] left_sv, right_sv, addend_sv;
	logic signed [PROD_W-1:0]     prod_s2;
	logic [ELEM_W-1:0]            addend_s2, addend_s3, addend_s4;
	logic signed [MAG_W-1:0]      prod_ext;
	logic [MAG_W-1:0]             mag_s3, shifted;
	logic                         neg_s3;
	logic [ELEM_W-1:0]            term_s4, acc_q, acc_base, acc_sum;

	assign left_sv   = left_rd;
	assign right_sv  = right_rd;
	assign addend_sv = addend_rd;
	assign prod_ext  = MAG_W'(prod_s2);
	assign shifted   = mag_s3 >> fraction_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
			flags_s2 <= '0;
			flags_s3 <= '0;
			flags_s4 <= '0;
		end else begin
			flags_s1 <= issue;
			flags_s2 <= flags_s1;
			flags_s3 <= flags_s2;
			flags_s4 <= flags_s3;
		end
	end

	// Multiply, take the magnitude, then scale and restore the sign, so that
	// the shift truncates toward zero.
	always_ff @(posedge clk) begin
		prod_s2   <= left_sv * right_sv;
		addend_s2 <= accumulate_mode ? ELEM_W'(addend_sv) : '0;
		neg_s3    <= prod_s2[PROD_W-1];
		mag_s3    <= prod_s2[PROD_W-1] ? -prod_ext : prod_ext;
		addend_s3 <= addend_s2;
		term_s4   <= neg_s3 ? -shifted[ELEM_W-1:0] : shifted[ELEM_W-1:0];
		addend_s4 <= addend_s3;
	end

	assign acc_base = flags_s4.first ? addend_s4 : acc_q;
	assign acc_sum  = acc_base + term_s4;

	always_ff @(posedge clk) begin
		if (flags_s4.valid) begin
			acc_q <= acc_sum;
		end
		if (flags_s4.valid && flags_s4.last_term) begin
			product_value <= acc_sum;
			last_element  <= flags_s4.last_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= flags_s4.valid && flags_s4.last_term;
		end
	end

	assign pipe_busy = flags_s1.valid || flags_s2.valid || flags_s3.valid
		|| flags_s4.valid || result_strobe;

endmodule

`default_nettype wire

FILE: rtl/fixed_point_matrix_multiply.sv
// ---------------------------------------------------------------------------
// fixed_point_matrix_multiply: signed fixed-point matrix product with addend
// Loads the left, right and optional addend matrices one element per
// transfer and streams out the scaled product matrix in row-major order.
// ---------------------------------------------------------------------------
// Elements are loaded one per cycle while busy is low: an element transfer
// takes place at each clock edge with start high and busy low, first the
// left matrix (left_rows by inner_size), then the right matrix (inner_size by
// right_cols), then, in accumulate mode, the addend matrix (left_rows by
// right_cols), all in row-major order. The transfer of the final element
// raises busy. The block then issues one multiply-accumulate per cycle, a
// rate set by the single multiplier and the one read port of each store,
// and busy falls again once the pipeline has drained. For eight-by-eight
// matrices a set is 128 loads, or 192 loads in accumulate mode. A result
// appears on product_value, marked by result_strobe for exactly one cycle,
// and the last one carries last_element. The receiver cannot hold results
// off and must take each one as it is shown. Each result is the addend (or
// zero) plus the sum over the inner index of the full product divided by two
// to the power fraction_bits, truncated toward zero; the sum wraps at 32 bits.
// Dimension registers holding zero act as one and those above MAX_DIM act as
// MAX_DIM. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while the block is idle, as the block itself
// does not enforce this, and any write to a defined register restarts loading
// from the first element.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_point_matrix_multiply #(
	parameter int MAX_DIM    = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [fpmm_pkg::ELEM_W-1:0]      element_value,
	output logic [fpmm_pkg::ELEM_W-1:0]      product_value,
	output logic                             last_element,
	output logic                             result_strobe,
	input  logic                             cfg_we,
	input  logic [fpmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import fpmm_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers. They hold the raw written values; clamping of
	// the dimensions happens in the controller.
	logic [DIM_REG_W-1:0] left_rows_q, inner_size_q, right_cols_q;
	logic                 accumulate_mode_q;
	logic [FRAC_W-1:0]    fraction_bits_q;
	logic                 cfg_restart;

	always_comb begin
		unique case (cfg_reg_t'(cfg_index))
			REG_LEFT_ROWS,
			REG_INNER_SIZE,
			REG_RIGHT_COLS,
			REG_ACCUMULATE_MODE,
			REG_FRACTION_BITS: cfg_restart = cfg_we;
			default:           cfg_restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q       <= LEFT_ROWS_RST;
			inner_size_q      <= INNER_SIZE_RST;
			right_cols_q      <= RIGHT_COLS_RST;
			accumulate_mode_q <= ACC_MODE_RST;
			fraction_bits_q   <= FRAC_BITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEFT_ROWS:       left_rows_q       <= cfg_data[DIM_REG_W-1:0];
				REG_INNER_SIZE:      inner_size_q      <= cfg_data[DIM_REG_W-1:0];
				REG_RIGHT_COLS:      right_cols_q      <= cfg_data[DIM_REG_W-1:0];
				REG_ACCUMULATE_MODE: accumulate_mode_q <= cfg_data[0];
				REG_FRACTION_BITS:   fraction_bits_q   <= cfg_data[FRAC_W-1:0];
				default: begin
					// Writes beyond the register list are ignored.
				end
			endcase
		end
	end

	// Command and status between the sequencer and the datapath.
	wr_sel_t           wr_sel;
	logic [ADDR_W-1:0] wr_addr, rd_left_addr, rd_right_addr, rd_addend_addr;
	issue_t            issue;
	logic              pipe_busy;

	fpmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.cfg_restart     (cfg_restart),
		.left_rows       (left_rows_q),
		.inner_size      (inner_size_q),
		.right_cols      (right_cols_q),
		.accumulate_mode (accumulate_mode_q),
		.pipe_busy       (pipe_busy),
		.busy            (busy),
		.wr_sel          (wr_sel),
		.wr_addr         (wr_addr),
		.rd_left_addr    (rd_left_addr),
		.rd_right_addr   (rd_right_addr),
		.rd_addend_addr  (rd_addend_addr),
		.issue           (issue)
	);

	fpmm_datapath #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.element_value   (element_value),
		.wr_sel          (wr_sel),
		.wr_addr         (wr_addr),
		.rd_left_addr    (rd_left_addr),
		.rd_right_addr   (rd_right_addr),
		.rd_addend_addr  (rd_addend_addr),
		.issue           (issue),
		.accumulate_mode (accumulate_mode_q),
		.fraction_bits   (fraction_bits_q),
		.product_value   (product_value),
		.last_element    (last_element),
		.result_strobe   (result_strobe),
		.pipe_busy       (pipe_busy)
	);

endmodule

`default_nettype wire

FILE: dv/fpmm_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpmm_result_checker: predicts and checks the matrix multiplier's results
// Follows register writes and element transfers on the block's ports, keeps
// its own copy of the matrices and computes each expected result element;
// every strobed result is compared with the oldest one still awaited.
// ---------------------------------------------------------------------------

module fpmm_result_checker #(
	parameter int MAX_DIM = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [fpmm_pkg::ELEM_W-1:0]     element_value,
	input  logic [fpmm_pkg::ELEM_W-1:0]     product_value,
	input  logic                            last_element,
	input  logic                            result_strobe,
	input  logic                            cfg_we,
	input  logic [fpmm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpmm_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending_results,
	output int                              results_checked,
	output int                              matrices_checked,
	output int                              set_length
);

	import fpmm_pkg::*;

	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

	typedef struct packed {
		logic [ELEM_W-1:0] value;
		logic              last;
	} result_elem_t;

	logic [DIM_REG_W-1:0] rows_reg;
	logic [DIM_REG_W-1:0] inner_reg;
	logic [DIM_REG_W-1:0] cols_reg;
	logic                 acc_reg;
	logic [FRAC_W-1:0]    frac_reg;
	int                   load_pos;

	logic [ELEM_W-1:0] left_elems   [STORE_DEPTH];
	logic [ELEM_W-1:0] right_elems  [STORE_DEPTH];
	logic [ELEM_W-1:0] addend_elems [STORE_DEPTH];

	result_elem_t awaited_results [$];

	function automatic int effective_dim(input logic [DIM_REG_W-1:0] code);
		if (code == '0)
			return 1;
		if (code > MAX_DIM)
			return MAX_DIM;
		return int'(code);
	endfunction

	function automatic int elements_per_set();
		int rows, inner, cols;
		rows  = effective_dim(rows_reg);
		inner = effective_dim(inner_reg);
		cols  = effective_dim(cols_reg);
		return rows * inner + inner * cols + (acc_reg ? rows * cols : 0);
	endfunction

	// Full signed product scaled down by 2^shift, truncated toward zero,
	// keeping the low 32 bits.
	function automatic logic [ELEM_W-1:0] scaled_term(input logic [ELEM_W-1:0] a,
			input logic [ELEM_W-1:0] b, input logic [FRAC_W-1:0] shift);
		longint            full;
		logic [63:0]       mag;
		logic [ELEM_W-1:0] low;
		full = longint'($signed(a)) * longint'($signed(b));
		mag  = (full < 0) ? 64'(-full) : 64'(full);
		low  = ELEM_W'(mag >> shift);
		return (full < 0) ? -low : low;
	endfunction

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_LEFT_ROWS:       rows_reg  = data[DIM_REG_W-1:0];
			REG_INNER_SIZE:      inner_reg = data[DIM_REG_W-1:0];
			REG_RIGHT_COLS:      cols_reg  = data[DIM_REG_W-1:0];
			REG_ACCUMULATE_MODE: acc_reg   = data[0];
			REG_FRACTION_BITS:   frac_reg  = data[FRAC_W-1:0];
			default:             return;
		endcase
		load_pos = 0;
	endtask

	task automatic take_element(input logic [ELEM_W-1:0] v);
		int                rows, inner, cols, n_left, n_right, total, pos;
		logic [ELEM_W-1:0] sum;
		result_elem_t      res;
		rows    = effective_dim(rows_reg);
		inner   = effective_dim(inner_reg);
		cols    = effective_dim(cols_reg);
		n_left  = rows * inner;
		n_right = inner * cols;
		total   = elements_per_set();
		if (load_pos >= total)
			load_pos = 0;
		pos = load_pos;
		if (pos < n_left)
			left_elems[pos] = v;
		else if (pos < n_left + n_right)
			right_elems[pos - n_left] = v;
		else
			addend_elems[pos - n_left - n_right] = v;
		load_pos = pos + 1;
		if (load_pos < total)
			return;
		load_pos = 0;
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				sum = acc_reg ? addend_elems[r * cols + c] : '0;
				for (int i = 0; i < inner; i++)
					sum += scaled_term(left_elems[r * inner + i],
						right_elems[i * cols + c], frac_reg);
				res.value = sum;
				res.last  = (r == rows - 1) && (c == cols - 1);
				awaited_results.push_back(res);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_elem_t head;
		if (!arst_n) begin
			rows_reg         = LEFT_ROWS_RST;
			inner_reg        = INNER_SIZE_RST;
			cols_reg         = RIGHT_COLS_RST;
			acc_reg          = ACC_MODE_RST;
			frac_reg         = FRAC_BITS_RST;
			load_pos         = 0;
			fail_count       = 0;
			results_checked  = 0;
			matrices_checked = 0;
			awaited_results.delete();
		end else begin
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			if (start && !busy)
				take_element(element_value);
			if (result_strobe) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: product_value %h, last_element %b",
						product_value, last_element);
					fail_count++;
				end else begin
					head = awaited_results.pop_front();
					results_checked++;
					if (head.last)
						matrices_checked++;
					if (product_value !== head.value) begin
						$error("product_value: expected %h, actual %h",
							head.value, product_value);
						fail_count++;
					end
					if (last_element !== head.last) begin
						$error("last_element: expected %b, actual %b",
							head.last, last_element);
						fail_count++;
					end
				end
			end
		end
		pending_results = awaited_results.size();
		set_length      = elements_per_set();
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: top level of the fixed-point matrix multiplier's verification
// Drives register writes and element transfers into the block, with a
// directed opening and a long randomised run, and leaves all prediction and
// comparison to the result checker instantiated beside it.
// ---------------------------------------------------------------------------

module testbench;

	import fpmm_pkg::*;

	// Dimensions are kept mostly small so that the run stays short; the
	// largest size still turns up now and then.
	localparam int MAX_DIM       = 8;
	localparam int NUM_REGS      = 5;
	localparam int RANDOM_ITEMS  = 430;
	// Cycles allowed after the last awaited result before the block is
	// treated as idle; comfortably above its pipeline tail.
	localparam int SETTLE_CYCLES = 16;
	// Cycles without any transfer, result or register write before the run
	// is declared hung. The longest quiet stretch of a healthy run is the
	// sender's longest gap plus the pipeline fill.
	localparam int QUIET_LIMIT   = 2000;

	// Index that lies beyond the register list; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(NUM_REGS);

	localparam logic [ELEM_W-1:0] MAX_POS = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] MIN_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [ELEM_W-1:0]     element_value;
	logic [ELEM_W-1:0]     product_value;
	logic                  last_element;
	logic                  result_strobe;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending_results;
	int results_checked;
	int matrices_checked;
	int set_length;

	int elements_sent;
	int random_sent;
	int reg_writes;
	int settings_used;
	int quiet_cycles;
	bit steady;

	fixed_point_matrix_multiply dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.element_value (element_value),
		.product_value (product_value),
		.last_element  (last_element),
		.result_strobe (result_strobe),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	fpmm_result_checker #(.MAX_DIM(MAX_DIM)) result_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.element_value    (element_value),
		.product_value    (product_value),
		.last_element     (last_element),
		.result_strobe    (result_strobe),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending_results  (pending_results),
		.results_checked  (results_checked),
		.matrices_checked (matrices_checked),
		.set_length       (set_length)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog: any element transfer, strobed result or register write counts
	// as progress. A block that stops making any of these ends the run.
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no activity for %0d cycles.", QUIET_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// Sender gaps: mostly none or short, with the odd long pause. During a
	// steady phase the sender never idles, so back-to-back transfers are seen.
	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Dimension codes: zero (acts as one), codes past MAX_DIM, including ones
	// whose fifth bit falls outside the four-bit register, the maximum itself,
	// and otherwise small sizes.
	function automatic logic [CFG_DATA_W-1:0] pick_dim_code();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return CFG_DATA_W'($urandom_range(MAX_DIM + 1, (1 << CFG_DATA_W) - 1));
		if (roll <= 3)
			return CFG_DATA_W'(MAX_DIM);
		return CFG_DATA_W'($urandom_range(1, 4));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input cfg_reg_t which);
		case (which)
			// Only bit zero matters; the upper bits are randomised as well.
			REG_ACCUMULATE_MODE: return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
			REG_FRACTION_BITS: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return '1;
					default: return CFG_DATA_W'($urandom_range(0, (1 << FRAC_W) - 1));
				endcase
			end
			default: return pick_dim_code();
		endcase
	endfunction

	// Element content: fully random words, small signed values that keep the
	// sums meaningful at most scales, or a mix weighted towards the extremes.
	function automatic logic [ELEM_W-1:0] pick_element(input int style);
		case (style)
			0: return ELEM_W'($urandom());
			1: return ELEM_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: begin
				case ($urandom_range(0, 5))
					0:       return '0;
					1:       return '1;
					2:       return MAX_POS;
					3:       return MIN_NEG;
					4:       return ELEM_W'(1);
					default: return ELEM_W'($urandom());
				endcase
			end
		endcase
	endfunction

	// All driving tasks are entered and left at a falling edge, so every
	// input changes half a period away from the edge that samples it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		reg_writes++;
	endtask

	// One element transfer: optionally idle first, then hold start high until
	// a rising edge finds busy low. Start is left high so that the next
	// transfer can follow without a gap.
	task automatic send_element(input logic [ELEM_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start         <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
		elements_sent++;
	endtask

	// Bring the block to rest: stop offering elements, wait for every awaited
	// result and for busy to fall, then let the pipeline tail run out. Only
	// then may the registers be touched.
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (busy !== 1'b0 || pending_results != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sends up to count elements; the randomised part stops once its share of
	// transfers has been sent, even part-way through a set.
	task automatic send_random_set(input int count);
		int style;
		style = $urandom_range(0, 2);
		repeat (count) begin
			if (random_sent >= RANDOM_ITEMS)
				break;
			send_element(pick_element(style));
			random_sent++;
		end
	endtask

	// A new setting: at least one real register is always written, so that
	// any half-loaded set left behind is discarded, and now and then a write
	// to an unused index, which must change nothing.
	task automatic configure_random();
		int must;
		must = $urandom_range(0, NUM_REGS - 1);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
				CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
		for (int k = 0; k < NUM_REGS; k++) begin
			if (k == must || $urandom_range(0, 1) == 1)
				write_reg(CFG_IDX_W'(k), pick_reg_value(cfg_reg_t'(k)));
		end
		settings_used++;
	endtask

	initial begin
		int sets;
		start         = 1'b0;
		element_value = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_LEFT_ROWS;
		cfg_data      = '0;
		arst_n        = 1'b0;
		elements_sent = 0;
		random_sent   = 0;
		reg_writes    = 0;
		settings_used = 0;
		steady        = 1'b1;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// One-by-one matrices with no scaling: the largest positive and
		// negative operands, whose full products wrap when cut to 32 bits.
		write_reg(REG_LEFT_ROWS, CFG_DATA_W'(1));
		write_reg(REG_INNER_SIZE, CFG_DATA_W'(1));
		write_reg(REG_RIGHT_COLS, CFG_DATA_W'(1));
		write_reg(REG_ACCUMULATE_MODE, '0);
		write_reg(REG_FRACTION_BITS, '0);
		settings_used++;
		send_element(MAX_POS);
		send_element(MAX_POS);
		send_element(MIN_NEG);
		send_element(MIN_NEG);
		send_element(MIN_NEG);
		send_element(MAX_POS);
		settle();

		// Largest scale with an addend: a small negative product truncates
		// to zero, and the most negative square scales to the sign bit.
		write_reg(REG_ACCUMULATE_MODE, CFG_DATA_W'(1));
		write_reg(REG_FRACTION_BITS, '1);
		settings_used++;
		send_element('1);
		send_element(ELEM_W'(1));
		send_element(ELEM_W'(5));
		send_element(MIN_NEG);
		send_element(MIN_NEG);
		send_element(MAX_POS);
		settle();

		// A register write part-way through a set restarts the load, so the
		// two elements already taken must be forgotten.
		send_element(ELEM_W'(3));
		send_element(ELEM_W'(4));
		settle();
		write_reg(REG_FRACTION_BITS, CFG_DATA_W'(8));
		settings_used++;
		send_element(ELEM_W'(32'h0001_0000));
		send_element(ELEM_W'(32'hFFFF_FF00));
		send_element(ELEM_W'(7));
		settle();

		// Out-of-range dimensions: zero rows act as one, an inner code whose
		// four register bits are zero acts as one, and nine columns act as
		// eight. A write to the unused index half-way must not restart loading.
		write_reg(REG_LEFT_ROWS, '0);
		write_reg(REG_INNER_SIZE, CFG_DATA_W'(1 << DIM_REG_W));
		write_reg(REG_RIGHT_COLS, CFG_DATA_W'(MAX_DIM + 1));
		write_reg(REG_ACCUMULATE_MODE, '0);
		settings_used++;
		repeat (4) send_element(pick_element(2));
		settle();
		write_reg(REG_SPARE, '1);
		repeat (5) send_element(pick_element(2));
		settle();

		// Randomised phases. Most phases load whole sets with random content;
		// about one in eight stops part-way, and the next setting must throw
		// the partial set away.
		while (random_sent < RANDOM_ITEMS) begin
			settle();
			configure_random();
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 7) == 0) begin
				send_random_set($urandom_range(1, set_length - 1));
			end else begin
				sets = $urandom_range(1, 3);
				repeat (sets) send_random_set(set_length);
			end
		end
		settle();

		$display("Run covered %0d element transfers and %0d register writes over %0d settings.",
			elements_sent, reg_writes, settings_used);
		$display("Checked %0d result elements, completing %0d result matrices.",
			results_checked, matrices_checked);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
